// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property macros for the swerve kinematics RTL. With SYNTH defined
// the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: hdl/sik_pkg.sv
// ----------------------------------------------------------------------------
// sik_pkg
// Types, constants and the arctangent table shared by the swerve drive
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package sik_pkg;

  // Number of CORDIC micro-rotations, one cell each (legal range 8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_WHEELS    = 4;

  // Front end takes two stages, the output end two more.
  localparam int PIPE_DEPTH = CORDIC_STAGES + 4;

  // Arctangent table has 24 entries.
  localparam int ATAN_IDX_W = 5;

  // CORDIC datapath widths: components carry 8 fraction bits plus growth,
  // the angle accumulates in units of 2^-32 of a turn with headroom.
  localparam int XW = 28;
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);

  // Gain compensation, 1/1.6467602581 in units of 2^-30.
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN = 30'd652032874;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = 1'b1;
  localparam logic [CFG_W-1:0]     BASE_RESET      = 16'd8192;

  // One wheel vector as it travels down the CORDIC chain.
  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  // Arctangent of 2^-i in units of 2^-32 of a turn.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:    val = ZW'(64'sd536870912);
      5'd1:    val = ZW'(64'sd316933406);
      5'd2:    val = ZW'(64'sd167458907);
      5'd3:    val = ZW'(64'sd85004756);
      5'd4:    val = ZW'(64'sd42667331);
      5'd5:    val = ZW'(64'sd21354465);
      5'd6:    val = ZW'(64'sd10679838);
      5'd7:    val = ZW'(64'sd5340245);
      5'd8:    val = ZW'(64'sd2670163);
      5'd9:    val = ZW'(64'sd1335087);
      5'd10:   val = ZW'(64'sd667544);
      5'd11:   val = ZW'(64'sd333772);
      5'd12:   val = ZW'(64'sd166886);
      5'd13:   val = ZW'(64'sd83443);
      5'd14:   val = ZW'(64'sd41722);
      5'd15:   val = ZW'(64'sd20861);
      5'd16:   val = ZW'(64'sd10430);
      5'd17:   val = ZW'(64'sd5215);
      5'd18:   val = ZW'(64'sd2608);
      5'd19:   val = ZW'(64'sd1304);
      5'd20:   val = ZW'(64'sd652);
      5'd21:   val = ZW'(64'sd326);
      5'd22:   val = ZW'(64'sd163);
      5'd23:   val = ZW'(64'sd81);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/sik_front.sv
// ----------------------------------------------------------------------------
// sik_front
// Two-stage front end: yaw rate products, then rounding, wheel vector sums
// with saturation and the quarter-turn pre-rotation into the CORDIC lanes.
// ----------------------------------------------------------------------------
module sik_front (
  input  logic                                            clk_i,
  input  logic                                            en_a_i,
  input  logic                                            en_b_i,
  input  logic signed [15:0]                              vel_x_i,
  input  logic signed [15:0]                              vel_y_i,
  input  logic signed [15:0]                              yaw_rate_i,
  input  logic [sik_pkg::CFG_W-1:0]                       base_length_i,
  input  logic [sik_pkg::CFG_W-1:0]                       base_width_i,
  output sik_pkg::lane_t [sik_pkg::NUM_WHEELS-1:0]        lanes_o
);

  logic signed [15:0] vx_q, vy_q;
  logic signed [32:0] pw_q, pl_q;
  logic signed [32:0] pw_d, pl_d;
  logic signed [14:0] tw, tl;
  logic signed [15:0] ex [sik_pkg::NUM_WHEELS];
  logic signed [15:0] ey [sik_pkg::NUM_WHEELS];
  sik_pkg::lane_t [sik_pkg::NUM_WHEELS-1:0] lanes_d, lanes_q;

  // Round the magnitude of a product by 2^-18, ties away from zero.
  function automatic logic signed [14:0] rot_round(input logic signed [32:0] p);
    logic [32:0] mag;
    logic [32:0] sum;
    logic [13:0] r;
    mag = p[32] ? 33'(-p) : 33'(p);
    sum = mag + 33'd131072;
    r   = sum[31:18];
    return p[32] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // Add or subtract a rotation term and clamp to 16 bits signed.
  function automatic logic signed [15:0] sum_sat(input logic signed [15:0] v,
                                                 input logic signed [14:0] t,
                                                 input logic              sub);
    logic signed [17:0] s;
    s = sub ? (18'(v) - 18'(t)) : (18'(v) + 18'(t));
    if (s > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (s < -18'sd32768) begin
      return 16'sh8000;
    end
    return 16'(s);
  endfunction

  // Stage A: yaw rate times each base size.
  assign pw_d = 33'(yaw_rate_i) * 33'($signed({1'b0, base_width_i}));
  assign pl_d = 33'(yaw_rate_i) * 33'($signed({1'b0, base_length_i}));

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
      pw_q <= pw_d;
      pl_q <= pl_d;
    end
  end

  // Stage B: rotation terms and the four wheel vectors.
  assign tw = rot_round(pw_q);
  assign tl = rot_round(pl_q);

  always_comb begin
    ex[0] = sum_sat(vx_q, tw, 1'b1);
    ey[0] = sum_sat(vy_q, tl, 1'b0);
    ex[1] = sum_sat(vx_q, tw, 1'b0);
    ey[1] = sum_sat(vy_q, tl, 1'b0);
    ex[2] = sum_sat(vx_q, tw, 1'b1);
    ey[2] = sum_sat(vy_q, tl, 1'b1);
    ex[3] = sum_sat(vx_q, tw, 1'b0);
    ey[3] = sum_sat(vy_q, tl, 1'b1);
  end

  // Scale by 2^8 and turn vectors in the left half plane by a quarter turn.
  always_comb begin
    logic signed [sik_pkg::XW-1:0] xs, ys;
    for (int l = 0; l < sik_pkg::NUM_WHEELS; l++) begin
      xs = sik_pkg::XW'(ex[l]) <<< 8;
      ys = sik_pkg::XW'(ey[l]) <<< 8;
      lanes_d[l].zero = (ex[l] == 16'sd0) && (ey[l] == 16'sd0);
      if (xs[sik_pkg::XW-1]) begin
        if (!ys[sik_pkg::XW-1]) begin
          lanes_d[l].x = ys;
          lanes_d[l].y = -xs;
          lanes_d[l].z = sik_pkg::Z_QUARTER;
        end else begin
          lanes_d[l].x = -ys;
          lanes_d[l].y = xs;
          lanes_d[l].z = -sik_pkg::Z_QUARTER;
        end
      end else begin
        lanes_d[l].x = xs;
        lanes_d[l].y = ys;
        lanes_d[l].z = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign lanes_o = lanes_q;

endmodule

// File: hdl/sik_cordic_cell.sv
// ----------------------------------------------------------------------------
// sik_cordic_cell
// One vectoring CORDIC micro-rotation for one wheel lane, registered.
// ----------------------------------------------------------------------------
module sik_cordic_cell (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [sik_pkg::ATAN_IDX_W-1:0]    stage_i,
  input  sik_pkg::lane_t                    lane_i,
  output sik_pkg::lane_t                    lane_o
);

  logic signed [sik_pkg::XW-1:0] x_in, y_in, dx, dy;
  logic signed [sik_pkg::ZW-1:0] z_in, da;
  sik_pkg::lane_t lane_d, lane_q;

  assign x_in = lane_i.x;
  assign y_in = lane_i.y;
  assign z_in = lane_i.z;

  // Floor shifts of the cross terms and this stage's angle step.
  assign dx = y_in >>> stage_i;
  assign dy = x_in >>> stage_i;
  assign da = sik_pkg::atan_lut(stage_i);

  // Rotate toward the x axis, steered by the sign of y.
  always_comb begin
    lane_d.zero = lane_i.zero;
    if (!y_in[sik_pkg::XW-1]) begin
      lane_d.x = x_in + dx;
      lane_d.y = y_in - dy;
      lane_d.z = z_in + da;
    end else begin
      lane_d.x = x_in - dx;
      lane_d.y = y_in + dy;
      lane_d.z = z_in - da;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// File: hdl/sik_post.sv
// ----------------------------------------------------------------------------
// sik_post
// Output end of one lane: gain compensation multiply and angle rounding,
// then speed rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module sik_post (
  input  logic           clk_i,
  input  logic           en_a_i,
  input  logic           en_b_i,
  input  sik_pkg::lane_t lane_i,
  output logic [15:0]    speed_o,
  output logic [15:0]    angle_o
);

  localparam int MAG_W  = sik_pkg::XW - 1;
  localparam int PROD_W = MAG_W + sik_pkg::GAIN_W;

  logic [MAG_W-1:0]          x_mag;
  logic [PROD_W-1:0]         prod_d, prod_q;
  logic signed [sik_pkg::ZW-1:0] ang_sum;
  logic [15:0]               ang_d, ang_a_q, ang_b_q;
  logic                      zero_a_q;
  logic [PROD_W:0]           rnd;
  logic [PROD_W-38:0]        spd_m;
  logic [15:0]               spd_d, spd_q;

  // Stage A: clamp x at zero, multiply by the gain, round the angle.
  assign x_mag   = lane_i.x[sik_pkg::XW-1] ? '0 : lane_i.x[MAG_W-1:0];
  assign prod_d  = PROD_W'(x_mag) * PROD_W'(sik_pkg::GAIN);
  assign ang_sum = lane_i.z + sik_pkg::ZW'(32768);
  assign ang_d   = lane_i.zero ? 16'd0 : ang_sum[31:16];

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      prod_q   <= prod_d;
      ang_a_q  <= ang_d;
      zero_a_q <= lane_i.zero;
    end
  end

  // Stage B: round the product by 2^-38, ties upward, and saturate.
  assign rnd   = {1'b0, prod_q} + ((PROD_W+1)'(1) << 37);
  assign spd_m = rnd[PROD_W:38];

  always_comb begin
    if (zero_a_q) begin
      spd_d = 16'd0;
    end else if (|spd_m[PROD_W-38:16]) begin
      spd_d = 16'hFFFF;
    end else begin
      spd_d = spd_m[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      spd_q   <= spd_d;
      ang_b_q <= ang_a_q;
    end
  end

  assign speed_o = spd_q;
  assign angle_o = ang_b_q;

endmodule

// File: hdl/swerve_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics: four-wheel swerve drive inverse kinematics.
// An accepted item passes the front end, the CORDIC cells and the output end.
// Throughput: one item per cycle while the output is taken, set by the chain
// of CORDIC cells, one micro-rotation per cell; idle stages are filled even while the output waits.
// Reset clears all valid bits and loads both base sizes with 8192 (0.5 m).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swerve_inverse_kinematics (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [sik_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sik_pkg::CFG_W-1:0]         cfg_data_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [15:0]                vel_x_i,
  input  logic signed [15:0]                vel_y_i,
  input  logic signed [15:0]                yaw_rate_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [15:0]                       front_left_speed_o,
  output logic signed [15:0]                front_left_angle_o,
  output logic [15:0]                       front_right_speed_o,
  output logic signed [15:0]                front_right_angle_o,
  output logic [15:0]                       back_left_speed_o,
  output logic signed [15:0]                back_left_angle_o,
  output logic [15:0]                       back_right_speed_o,
  output logic signed [15:0]                back_right_angle_o
);

  localparam int P = sik_pkg::PIPE_DEPTH;

  logic [sik_pkg::CFG_W-1:0] base_length_q, base_width_q;
  logic [P-1:0]              valid_q, valid_d, en;
  logic                      in_acc, out_acc;

  sik_pkg::lane_t [sik_pkg::NUM_WHEELS-1:0] front_lanes;
  sik_pkg::lane_t chain [sik_pkg::NUM_WHEELS][sik_pkg::CORDIC_STAGES];
  logic [15:0] spd [sik_pkg::NUM_WHEELS];
  logic [15:0] ang [sik_pkg::NUM_WHEELS];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_length_q <= sik_pkg::BASE_RESET;
      base_width_q  <= sik_pkg::BASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sik_pkg::REG_BASE_LENGTH: base_length_q <= cfg_data_i;
        sik_pkg::REG_BASE_WIDTH:  base_width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[P-1] = !valid_q[P-1] || out_ready_i;
    for (int k = P - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int k = 0; k < P; k++) begin
      if (en[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[P-1];
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // Front end: wheel vectors.
  sik_front u_front (
    .clk_i         (clk_i),
    .en_a_i        (en[0]),
    .en_b_i        (en[1]),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .yaw_rate_i    (yaw_rate_i),
    .base_length_i (base_length_q),
    .base_width_i  (base_width_q),
    .lanes_o       (front_lanes)
  );

  // One chain of CORDIC cells per wheel, then the output end.
  for (genvar l = 0; l < sik_pkg::NUM_WHEELS; l++) begin : g_lane
    for (genvar k = 0; k < sik_pkg::CORDIC_STAGES; k++) begin : g_cell
      sik_pkg::lane_t cell_in;
      if (k == 0) begin : g_first
        assign cell_in = front_lanes[l];
      end else begin : g_next
        assign cell_in = chain[l][k-1];
      end
      sik_cordic_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (en[k+2]),
        .stage_i (sik_pkg::ATAN_IDX_W'(k)),
        .lane_i  (cell_in),
        .lane_o  (chain[l][k])
      );
    end

    sik_post u_post (
      .clk_i   (clk_i),
      .en_a_i  (en[P-2]),
      .en_b_i  (en[P-1]),
      .lane_i  (chain[l][sik_pkg::CORDIC_STAGES-1]),
      .speed_o (spd[l]),
      .angle_o (ang[l])
    );
  end

  assign front_left_speed_o  = spd[0];
  assign front_left_angle_o  = ang[0];
  assign front_right_speed_o = spd[1];
  assign front_right_angle_o = ang[1];
  assign back_left_speed_o   = spd[2];
  assign back_left_angle_o   = ang[2];
  assign back_right_speed_o  = spd[3];
  assign back_right_angle_o  = ang[3];

  // An empty output stage means the whole chain can move, so input is open.
  `ASSERT_PROP(a_ready_when_drained, clk_i, rst_ni, !valid_q[P-1] |-> in_ready_o)

  // Items in flight change only by accepted inputs and delivered results.
  `ASSERT_PROP(a_item_count, clk_i, rst_ni, $past(rst_ni) |-> $countones(valid_q) == $countones($past(valid_q)) + 32'($past(in_acc)) - 32'($past(out_acc)))

  // After the pre-rotation every wheel vector lies in the right half plane.
  `ASSERT_NEVER(a_prerot_right_half, clk_i, rst_ni, valid_q[1] && (front_lanes[0].x[sik_pkg::XW-1] || front_lanes[1].x[sik_pkg::XW-1] || front_lanes[2].x[sik_pkg::XW-1] || front_lanes[3].x[sik_pkg::XW-1]))

endmodule
